@@ hdl/ttr4_pkg.sv @@
// Shared types, register codes and constants for the 4-D tensor transpose unit.
`timescale 1ns / 1ps

package ttr4_pkg;

    localparam int NUM_AXES   = 4;
    localparam int AXIS_W     = 2;
    localparam int SIZE_W     = 13;
    localparam int PERM_W     = 8;
    localparam int BYTE_W     = 8;
    localparam int DEST_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // word queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIM0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIM3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd5;

    localparam logic [SIZE_W-1:0] SIZE_RESET  = 13'd1;
    localparam logic [PERM_W-1:0] PERM_RESET  = 8'd228;
    localparam logic [BYTE_W-1:0] BYTE_OFFSET = 8'h80;

    typedef logic [SIZE_W-1:0] size_t;

    typedef struct packed {
        size_t [NUM_AXES-1:0] eff_size;
        logic  [PERM_W-1:0]   perm;
        logic                 offset_mode;
    } cfg_t;

    // zero acts as one, anything above the cap acts as the cap
    function automatic size_t eff_size(input size_t raw, input size_t cap);
        size_t res;
        if (raw == '0)
            res = size_t'(1);
        else if (raw > cap)
            res = cap;
        else
            res = raw;
        return res;
    endfunction

endpackage

@@ hdl/ttr4_front.sv @@
// Front end: accepts words, steps the coordinate counters, builds queue entries.
`timescale 1ns / 1ps

module ttr4_front #(
    parameter int CNT_W = 12
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  ttr4_pkg::cfg_t                                cfg,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic signed [ttr4_pkg::BYTE_W-1:0]            element_value,
    input  logic                                          q_ready,
    output logic                                          push,
    output logic [ttr4_pkg::NUM_AXES-1:0][CNT_W-1:0]      push_coords,
    output logic                                          push_last,
    output logic [ttr4_pkg::BYTE_W-1:0]                   push_byte
);
    import ttr4_pkg::*;

    logic [NUM_AXES-1:0][CNT_W-1:0] cnt_reg;
    logic [NUM_AXES-1:0][CNT_W-1:0] cnt_next;
    logic [NUM_AXES-1:0]            at_end;
    logic [NUM_AXES:0]              carry;

    always_comb
    begin
        carry[NUM_AXES] = 1'b1;
        for (int k = NUM_AXES - 1; k >= 0; k--)
        begin
            // counter may sit past a shrunk size; it then counts as at its end
            at_end[k] = ((SIZE_W + 1)'(cnt_reg[k]) + (SIZE_W + 1)'(1))
                        >= (SIZE_W + 1)'(cfg.eff_size[k]);
            carry[k] = carry[k + 1] & at_end[k];
            if (!carry[k + 1])
                cnt_next[k] = cnt_reg[k];
            else if (at_end[k])
                cnt_next[k] = '0;
            else
                cnt_next[k] = cnt_reg[k] + CNT_W'(1);
        end
    end

    assign in_ready    = q_ready;
    assign push        = in_valid & q_ready;
    assign push_coords = cnt_reg;
    assign push_last   = &at_end;
    assign push_byte   = cfg.offset_mode ? (element_value ^ BYTE_OFFSET) : element_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (push)
            cnt_reg <= cnt_next;
    end

endmodule

@@ hdl/ttr4_queue.sv @@
// Short word queue decoupling the counter front end from the index pipeline.
`timescale 1ns / 1ps

module ttr4_queue #(
    parameter int WIDTH = 57
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             not_full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);
    import ttr4_pkg::*;

    logic [WIDTH-1:0]   entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign not_full   = count_reg != Q_CNT_W'(Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push & not_full;
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + Q_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ hdl/ttr4_back.sv @@
// Back end: three-stage multiply-add pipeline forming the transposed index.
`timescale 1ns / 1ps

module ttr4_back #(
    parameter int CNT_W      = 12,
    parameter int INDEX_BITS = 24
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  ttr4_pkg::cfg_t                                cfg,
    input  logic                                          head_valid,
    input  logic [ttr4_pkg::NUM_AXES-1:0][CNT_W-1:0]      head_coords,
    input  logic                                          head_last,
    input  logic [ttr4_pkg::BYTE_W-1:0]                   head_byte,
    output logic                                          pop,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [ttr4_pkg::DEST_W-1:0]                   dest_index,
    output logic [ttr4_pkg::BYTE_W-1:0]                   out_byte,
    output logic                                          last_element,
    output logic                                          index_overflow
);
    import ttr4_pkg::*;

    localparam int AW      = (INDEX_BITS > CNT_W) ? INDEX_BITS : CNT_W;
    localparam int TW      = AW + SIZE_W + 1;
    localparam int NSTAGE  = 3;

    typedef logic [NUM_AXES-1:0][CNT_W-1:0] crd_t;

    logic [NSTAGE-1:0]  vld_reg;
    logic [AW-1:0]      acc_reg  [NSTAGE];
    logic [NSTAGE-1:0]  ovf_reg;
    crd_t               crd_reg  [NSTAGE];
    logic [BYTE_W-1:0]  byte_reg [NSTAGE];
    logic [NSTAGE-1:0]  last_reg;

    logic [AW-1:0]      acc_in   [NSTAGE];
    crd_t               crd_in   [NSTAGE];
    logic [NSTAGE-1:0]  ovf_in;
    logic [TW-1:0]      mac      [NSTAGE];
    logic [AW-1:0]      acc_next [NSTAGE];
    logic [NSTAGE-1:0]  ovf_next;
    logic [AXIS_W-1:0]  src      [NSTAGE];
    logic [AXIS_W-1:0]  src0;
    logic               en;

    // Horner step: acc * size + coord; acc holds only the low index bits
    function automatic logic [TW-1:0] mul_add(input logic [AW-1:0] acc,
                                              input size_t sz,
                                              input logic [CNT_W-1:0] crd);
        return TW'(acc) * TW'(sz) + TW'(crd);
    endfunction

    assign en  = !vld_reg[NSTAGE-1] || out_ready;
    assign pop = en && head_valid;
    assign src0 = cfg.perm[AXIS_W-1:0];

    always_comb
    begin
        for (int s = 0; s < NSTAGE; s++)
        begin
            if (s == 0)
            begin
                acc_in[s] = AW'(head_coords[src0]);
                crd_in[s] = head_coords;
                ovf_in[s] = 1'b0;
            end
            else
            begin
                acc_in[s] = acc_reg[s - 1];
                crd_in[s] = crd_reg[s - 1];
                ovf_in[s] = ovf_reg[s - 1];
            end
            src[s]      = cfg.perm[AXIS_W * (s + 1) +: AXIS_W];
            mac[s]      = mul_add(acc_in[s], cfg.eff_size[src[s]], crd_in[s][src[s]]);
            acc_next[s] = AW'(mac[s][INDEX_BITS-1:0]);
            // the sum only grows, so overflow is sticky
            ovf_next[s] = ovf_in[s] | (|mac[s][TW-1:INDEX_BITS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTAGE-2:0], head_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NSTAGE; s++)
            begin
                acc_reg[s] <= acc_next[s];
                ovf_reg[s] <= ovf_next[s];
                crd_reg[s] <= crd_in[s];
            end
            byte_reg[0] <= head_byte;
            last_reg[0] <= head_last;
            for (int s = 1; s < NSTAGE; s++)
            begin
                byte_reg[s] <= byte_reg[s - 1];
                last_reg[s] <= last_reg[s - 1];
            end
        end
    end

    assign out_valid      = vld_reg[NSTAGE-1];
    assign dest_index     = DEST_W'(acc_reg[NSTAGE-1]);
    assign out_byte       = byte_reg[NSTAGE-1];
    assign last_element   = last_reg[NSTAGE-1];
    assign index_overflow = ovf_reg[NSTAGE-1];

endmodule

@@ hdl/tensor_transpose_4d_unit.sv @@
// Top level of the 4-D int8 tensor transpose unit: registers, front, queue, back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------------
//   input    | in_valid / in_ready    | element_value (int8)
//   output   | out_valid / out_ready  | dest_index, out_byte, last_element,
//            |                        | index_overflow
//   config   | cfg_write (no wait)    | cfg_index, cfg_data
//
// Sustained rate is one word per cycle while out_ready stays high; the index multiply-add pipeline advances
// whenever its output register is empty or being taken.
// When nothing stalls, an accepted word is written into the queue, and the queue
// head feeds the first multiply-add stage directly, so the word then moves through
// the three stage registers in turn before output valid rises.
// Reset clears the coordinate counters, the queue and the pipeline valid bits and
// returns the registers to sizes 1, identity permutation and plain mode.
// A stalled output stops the pipeline; the queue then fills and input ready drops
// once it holds four words.
`timescale 1ns / 1ps

module tensor_transpose_4d_unit #(
    parameter int MAX_DIM    = 4096,
    parameter int INDEX_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [ttr4_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ttr4_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [ttr4_pkg::BYTE_W-1:0]   element_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ttr4_pkg::DEST_W-1:0]          dest_index,
    output logic [ttr4_pkg::BYTE_W-1:0]          out_byte,
    output logic                                 last_element,
    output logic                                 index_overflow
);
    import ttr4_pkg::*;

    // Sizes beyond the 13-bit register can never be written, so the cap and the
    // counters never need more than SIZE_W bits.
    localparam int SIZE_MAX = (1 << SIZE_W) - 1;
    localparam int EFF_CAP  = (MAX_DIM > SIZE_MAX) ? SIZE_MAX : MAX_DIM;
    localparam int CNT_W    = ($clog2(MAX_DIM) < SIZE_W) ? $clog2(MAX_DIM) : SIZE_W;
    localparam int ENTRY_W  = BYTE_W + 1 + NUM_AXES * CNT_W;
    localparam size_t CAP   = size_t'(EFF_CAP);

    size_t              size_reg [NUM_AXES];
    logic [PERM_W-1:0]  perm_reg;
    logic               offset_reg;
    cfg_t               cfg;

    logic                           q_not_full;
    logic                           push;
    logic [NUM_AXES-1:0][CNT_W-1:0] push_coords;
    logic                           push_last;
    logic [BYTE_W-1:0]              push_byte;
    logic                           pop;
    logic                           head_valid;
    logic [ENTRY_W-1:0]             head_data;
    logic [NUM_AXES-1:0][CNT_W-1:0] head_coords;
    logic                           head_last;
    logic [BYTE_W-1:0]              head_byte;

    // Configuration registers; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_AXES; k++)
                size_reg[k] <= SIZE_RESET;
            perm_reg   <= PERM_RESET;
            offset_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index) inside
                REG_DIM0, REG_DIM1, REG_DIM2, REG_DIM3:
                    size_reg[cfg_index[AXIS_W-1:0]] <= cfg_data[SIZE_W-1:0];
                REG_PERM:
                    perm_reg <= cfg_data[PERM_W-1:0];
                REG_OFFSET:
                    offset_reg <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    // Effective sizes: zero reads as one, oversize reads as the cap
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
            cfg.eff_size[k] = eff_size(size_reg[k], CAP);
        cfg.perm        = perm_reg;
        cfg.offset_mode = offset_reg;
    end

    ttr4_front #(
        .CNT_W (CNT_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_value (element_value),
        .q_ready       (q_not_full),
        .push          (push),
        .push_coords   (push_coords),
        .push_last     (push_last),
        .push_byte     (push_byte)
    );

    ttr4_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_byte, push_last, push_coords}),
        .not_full   (q_not_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign head_coords = head_data[NUM_AXES*CNT_W-1:0];
    assign head_last   = head_data[NUM_AXES*CNT_W];
    assign head_byte   = head_data[ENTRY_W-1 -: BYTE_W];

    ttr4_back #(
        .CNT_W      (CNT_W),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .head_valid     (head_valid),
        .head_coords    (head_coords),
        .head_last      (head_last),
        .head_byte      (head_byte),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .dest_index     (dest_index),
        .out_byte       (out_byte),
        .last_element   (last_element),
        .index_overflow (index_overflow)
    );

endmodule

@@ hdl/ttr4_checker.sv @@
// Port-level checks for the tensor transpose unit, bound to the top level.
`timescale 1ns / 1ps

module ttr4_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [ttr4_pkg::DEST_W-1:0]     dest_index,
    input logic [ttr4_pkg::BYTE_W-1:0]     out_byte,
    input logic                            last_element,
    input logic                            index_overflow
);
    import ttr4_pkg::*;

    // queue can only be full while the output is held
    a_ready_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input blocked with no word waiting at the output");

    // space reopens only after an output word is taken
    a_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> $past(out_valid && out_ready))
        else $error("input ready rose without an output word taken");

    // an offered input word stays on offer until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input word withdrawn before it was taken");

    // a stalled output word holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dest_index)
            && $stable(out_byte) && $stable(last_element) && $stable(index_overflow))
        else $error("output word changed while stalled");

endmodule

bind tensor_transpose_4d_unit ttr4_checker u_ttr4_checker (.*);
